@@ hw/rtl/kpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpp_pkg
// Shared constants, types and helpers of the planar pose Kalman predictor.
// ----------------------------------------------------------------------------
package kpp_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int ANGLE_BITS   = 30;
  localparam int CSHIFT       = ANGLE_BITS - FRAC_BITS;

  localparam int NOISE_W = 20;
  localparam int IDX_W   = 3;
  localparam int DT_W    = 17;
  localparam int WRAP_W  = 26;
  localparam int WRAP_STEPS = 6;
  localparam int ACC_W   = 56;

  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032875;

  localparam longint PI_Q      = (64'sd3373259426 + (64'sd1 <<< (CSHIFT - 1))) >>> CSHIFT;
  localparam longint TWO_PI_Q  = 2 * PI_Q;
  localparam longint WRAP_BIAS = TWO_PI_Q <<< (WRAP_STEPS - 1);
  localparam longint WRAP_OFS  = PI_Q + WRAP_BIAS;

  localparam longint VAR_A    = ((64'sd5 <<< FRAC_BITS) + 50) / 100;
  localparam longint VAR_B    = ((64'sd2 <<< FRAC_BITS) + 50) / 100;
  localparam longint ONE_SEC  = 64'sd65536;

  localparam logic [IDX_W-1:0] REG_NOISE_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_NOISE_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_NOISE_HEAD = 3'd2;
  localparam logic [IDX_W-1:0] REG_NOISE_VX   = 3'd3;
  localparam logic [IDX_W-1:0] REG_NOISE_VY   = 3'd4;
  localparam logic [IDX_W-1:0] REG_NOISE_TURN = 3'd5;

  localparam logic [NOISE_W-1:0] RST_NOISE_X    = 20'd3277;
  localparam logic [NOISE_W-1:0] RST_NOISE_Y    = 20'd3277;
  localparam logic [NOISE_W-1:0] RST_NOISE_HEAD = 20'd1311;
  localparam logic [NOISE_W-1:0] RST_NOISE_VX   = 20'd6554;
  localparam logic [NOISE_W-1:0] RST_NOISE_VY   = 20'd3277;
  localparam logic [NOISE_W-1:0] RST_NOISE_TURN = 20'd3277;

  localparam int OPCODE_INIT = 0;

  typedef logic [3:0] mop_t;
  localparam mop_t OP_VX   = 4'd0;
  localparam mop_t OP_VY   = 4'd1;
  localparam mop_t OP_X    = 4'd2;
  localparam mop_t OP_Y    = 4'd3;
  localparam mop_t OP_HD   = 4'd4;
  localparam mop_t OP_HDT  = 4'd5;
  localparam mop_t OP_VAR0 = 4'd6;
  localparam mop_t OP_VAR1 = 4'd7;
  localparam mop_t OP_VAR2 = 4'd8;

  typedef logic [WRAP_W-1:0] wrap_t;
  typedef logic [DT_W-1:0] dt_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic capture;
    logic load_pose;
    logic rec_stamp;
    logic cordic_start;
    logic cordic_step;
    logic cordic_fin;
    logic mul;
    logic acc;
    mop_t mop;
    logic wrap_step;
    logic wrap_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic dt_ok;
    logic cordic_last;
    logic wrap_last;
    logic out_free;
  } status_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] k);
    logic signed [33:0] r;
    unique case (k)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837830;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021688;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388438;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      default: r = 34'sd1 <<< (5'd30 - k);
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input acc_t v);
    logic signed [31:0] r;
    if (v > acc_t'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < acc_t'(-64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [30:0] satu31(input acc_t v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > acc_t'(64'sd2147483647)) begin
      r = '1;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/kpp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpp_if
// Request and result channels of the planar pose Kalman predictor.
// ----------------------------------------------------------------------------
interface kpp_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [18:0] pose_heading;
  logic signed [23:0] speed;
  logic signed [23:0] turn_rate;
  logic        [31:0] stamp;

  modport source (output valid, opcode, pose_x, pose_y, pose_heading, speed,
                  turn_rate, stamp, input ready);
  modport sink (input valid, opcode, pose_x, pose_y, pose_heading, speed,
                turn_rate, stamp, output ready);
endinterface

interface kpp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic signed [18:0] est_heading;
  logic        [30:0] var_x;
  logic        [30:0] var_y;
  logic        [30:0] var_heading;
  logic signed [31:0] cov_xy;

  modport source (output valid, est_x, est_y, est_heading, var_x, var_y,
                  var_heading, cov_xy, input ready);
  modport sink (input valid, est_x, est_y, est_heading, var_x, var_y,
                var_heading, cov_xy, output ready);
endinterface

@@ hw/rtl/kpp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpp_datapath
// Filter state, noise registers, CORDIC, shared multiplier, heading wrap
// unit and result register.
// ----------------------------------------------------------------------------
module kpp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  kpp_pkg::cmd_t                 cmd,
  output kpp_pkg::status_t              status,
  input  logic                          cfg_we,
  input  logic [kpp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [kpp_pkg::NOISE_W-1:0]   cfg_data,
  input  logic                          opcode,
  input  logic signed [31:0]            pose_x,
  input  logic signed [31:0]            pose_y,
  input  logic signed [18:0]            pose_heading,
  input  logic signed [23:0]            speed,
  input  logic signed [23:0]            turn_rate,
  input  logic [31:0]                   stamp,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [31:0]            est_x,
  output logic signed [31:0]            est_y,
  output logic signed [18:0]            est_heading,
  output logic [30:0]                   var_x,
  output logic [30:0]                   var_y,
  output logic [30:0]                   var_heading
);

  logic                        in_op;
  logic signed [31:0]          in_px, in_py;
  logic signed [18:0]          in_ph;
  logic signed [23:0]          in_speed, in_turn;
  logic [31:0]                 in_stamp;

  logic [kpp_pkg::NOISE_W-1:0] npos [3];
  logic [kpp_pkg::NOISE_W-1:0] nvel [3];

  logic signed [31:0]          mx, my, vx, vy;
  logic signed [18:0]          mh;
  logic [30:0]                 pvar [3];
  logic [kpp_pkg::NOISE_W-1:0] vvar [3];
  logic [31:0]                 last_stamp;
  kpp_pkg::dt_t                dt, hdt;

  logic signed [33:0]          cz, cx, cy;
  logic [4:0]                  ck;
  logic                        cflip;
  logic signed [19:0]          cos_q, sin_q;

  logic signed [32:0]          ma;
  logic signed [20:0]          mb;
  logic signed [53:0]          prod, rnd;

  kpp_pkg::wrap_t              wrap_u, thr;
  logic [2:0]                  wk;

  logic [31:0]                 d;
  logic [1:0]                  vi;
  logic signed [33:0]          zt, xf, yf;
  kpp_pkg::acc_t               hsum, vsum;
  logic signed [27:0]          hfin;

  assign d  = in_stamp - last_stamp;
  assign vi = 2'(cmd.mop - kpp_pkg::OP_VAR0);
  assign zt = 34'(mh) <<< kpp_pkg::CSHIFT;
  assign xf = cflip ? -cx : cx;
  assign yf = cflip ? -cy : cy;
  assign rnd = (prod + (54'sd1 <<< (kpp_pkg::FRAC_BITS - 1))) >>> kpp_pkg::FRAC_BITS;
  assign thr = kpp_pkg::wrap_t'(kpp_pkg::TWO_PI_Q) << wk;
  assign hsum = kpp_pkg::acc_t'(mh) + kpp_pkg::acc_t'(rnd);
  assign vsum = kpp_pkg::acc_t'(signed'({1'b0, pvar[vi]})) + kpp_pkg::acc_t'(rnd)
              + kpp_pkg::acc_t'(signed'({1'b0, npos[vi]}));
  assign hfin = 28'(kpp_pkg::PI_Q) - 28'(signed'({1'b0, wrap_u}));

  assign status.opcode      = in_op;
  assign status.dt_ok       = (d != '0) && (d <= 32'(kpp_pkg::ONE_SEC));
  assign status.cordic_last = (ck == 5'(kpp_pkg::CORDIC_STEPS - 1));
  assign status.wrap_last   = (wk == '0);
  assign status.out_free    = !out_valid || out_ready;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mop)
      kpp_pkg::OP_VX: begin
        ma = 33'(in_speed);
        mb = 21'(cos_q);
      end
      kpp_pkg::OP_VY: begin
        ma = 33'(in_speed);
        mb = 21'(sin_q);
      end
      kpp_pkg::OP_X: begin
        ma = 33'(vx);
        mb = 21'(signed'({1'b0, dt}));
      end
      kpp_pkg::OP_Y: begin
        ma = 33'(vy);
        mb = 21'(signed'({1'b0, dt}));
      end
      kpp_pkg::OP_HD: begin
        ma = 33'(in_turn);
        mb = 21'(signed'({1'b0, dt}));
      end
      kpp_pkg::OP_HDT: begin
        ma = 33'(signed'({1'b0, dt}));
        mb = 21'(signed'({1'b0, dt}));
      end
      kpp_pkg::OP_VAR0, kpp_pkg::OP_VAR1, kpp_pkg::OP_VAR2: begin
        ma = 33'(signed'({1'b0, vvar[vi]}));
        mb = 21'(signed'({1'b0, hdt}));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_op    <= opcode;
      in_px    <= pose_x;
      in_py    <= pose_y;
      in_ph    <= pose_heading;
      in_speed <= speed;
      in_turn  <= turn_rate;
      in_stamp <= stamp;
    end
  end

  // noise registers
  always_ff @(posedge clk) begin
    if (rst) begin
      npos[0] <= kpp_pkg::RST_NOISE_X;
      npos[1] <= kpp_pkg::RST_NOISE_Y;
      npos[2] <= kpp_pkg::RST_NOISE_HEAD;
      nvel[0] <= kpp_pkg::RST_NOISE_VX;
      nvel[1] <= kpp_pkg::RST_NOISE_VY;
      nvel[2] <= kpp_pkg::RST_NOISE_TURN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpp_pkg::REG_NOISE_X:    npos[0] <= cfg_data;
        kpp_pkg::REG_NOISE_Y:    npos[1] <= cfg_data;
        kpp_pkg::REG_NOISE_HEAD: npos[2] <= cfg_data;
        kpp_pkg::REG_NOISE_VX:   nvel[0] <= cfg_data;
        kpp_pkg::REG_NOISE_VY:   nvel[1] <= cfg_data;
        kpp_pkg::REG_NOISE_TURN: nvel[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      mx         <= '0;
      my         <= '0;
      mh         <= '0;
      last_stamp <= '0;
      pvar[0]    <= 31'(kpp_pkg::VAR_A);
      pvar[1]    <= 31'(kpp_pkg::VAR_A);
      pvar[2]    <= 31'(kpp_pkg::VAR_B);
      vvar[0]    <= 20'(kpp_pkg::VAR_A);
      vvar[1]    <= 20'(kpp_pkg::VAR_A);
      vvar[2]    <= 20'(kpp_pkg::VAR_B);
    end else begin
      if (cmd.load_pose) begin
        mx      <= in_px;
        my      <= in_py;
        pvar[0] <= 31'(kpp_pkg::VAR_A);
        pvar[1] <= 31'(kpp_pkg::VAR_A);
        pvar[2] <= 31'(kpp_pkg::VAR_B);
        vvar[0] <= 20'(kpp_pkg::VAR_A);
        vvar[1] <= 20'(kpp_pkg::VAR_A);
        vvar[2] <= 20'(kpp_pkg::VAR_B);
      end
      if (cmd.rec_stamp) begin
        last_stamp <= in_stamp;
      end
      if (cmd.acc) begin
        unique case (cmd.mop)
          kpp_pkg::OP_X: mx <= kpp_pkg::sat32(kpp_pkg::acc_t'(mx) + kpp_pkg::acc_t'(rnd));
          kpp_pkg::OP_Y: my <= kpp_pkg::sat32(kpp_pkg::acc_t'(my) + kpp_pkg::acc_t'(rnd));
          kpp_pkg::OP_VAR0, kpp_pkg::OP_VAR1, kpp_pkg::OP_VAR2: begin
            pvar[vi] <= kpp_pkg::satu31(vsum);
            vvar[vi] <= nvel[vi];
          end
          default: ;
        endcase
      end
      if (cmd.wrap_fin) begin
        mh <= hfin[18:0];
      end
    end
  end

  // step, cordic, multiplier and wrap datapath
  always_ff @(posedge clk) begin
    if (cmd.rec_stamp) begin
      dt <= d[kpp_pkg::DT_W-1:0];
    end
    if (cmd.cordic_start) begin
      cx <= kpp_pkg::GAIN_Q30;
      cy <= '0;
      ck <= '0;
      if (zt > kpp_pkg::HALF_PI_Q30) begin
        cz    <= zt - kpp_pkg::PI_Q30;
        cflip <= 1'b1;
      end else if (zt < -kpp_pkg::HALF_PI_Q30) begin
        cz    <= zt + kpp_pkg::PI_Q30;
        cflip <= 1'b1;
      end else begin
        cz    <= zt;
        cflip <= 1'b0;
      end
    end
    if (cmd.cordic_step) begin
      if (!cz[33]) begin
        cx <= cx - (cy >>> ck);
        cy <= cy + (cx >>> ck);
        cz <= cz - kpp_pkg::atan_q30(ck);
      end else begin
        cx <= cx + (cy >>> ck);
        cy <= cy - (cx >>> ck);
        cz <= cz + kpp_pkg::atan_q30(ck);
      end
      ck <= ck + 5'd1;
    end
    if (cmd.cordic_fin) begin
      cos_q <= 20'((xf + (34'sd1 <<< (kpp_pkg::CSHIFT - 1))) >>> kpp_pkg::CSHIFT);
      sin_q <= 20'((yf + (34'sd1 <<< (kpp_pkg::CSHIFT - 1))) >>> kpp_pkg::CSHIFT);
    end
    if (cmd.mul) begin
      prod <= ma * mb;
    end
    if (cmd.acc) begin
      unique case (cmd.mop)
        kpp_pkg::OP_VX:  vx <= kpp_pkg::sat32(kpp_pkg::acc_t'(rnd));
        kpp_pkg::OP_VY:  vy <= kpp_pkg::sat32(kpp_pkg::acc_t'(rnd));
        kpp_pkg::OP_HD: begin
          wrap_u <= kpp_pkg::wrap_t'(kpp_pkg::acc_t'(kpp_pkg::WRAP_OFS) - hsum);
          wk     <= 3'(kpp_pkg::WRAP_STEPS - 1);
        end
        kpp_pkg::OP_HDT: hdt <= rnd[kpp_pkg::DT_W-1:0];
        default: ;
      endcase
    end
    if (cmd.load_pose) begin
      wrap_u <= kpp_pkg::wrap_t'(kpp_pkg::acc_t'(kpp_pkg::WRAP_OFS) - kpp_pkg::acc_t'(in_ph));
      wk     <= 3'(kpp_pkg::WRAP_STEPS - 1);
    end
    if (cmd.wrap_step) begin
      if (wrap_u >= thr) begin
        wrap_u <= wrap_u - thr;
      end
      wk <= wk - 3'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      est_x       <= mx;
      est_y       <= my;
      est_heading <= mh;
      var_x       <= pvar[0];
      var_y       <= pvar[1];
      var_heading <= pvar[2];
    end
  end

endmodule

@@ hw/rtl/kpp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpp_ctrl
// Sequencer of the planar pose Kalman predictor: item decode, CORDIC
// iterations, multiply-accumulate schedule, heading wrap and result transfer.
// ----------------------------------------------------------------------------
module kpp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  kpp_pkg::status_t status,
  output kpp_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_CINIT  = 4'd2;
  localparam logic [3:0] S_CITER  = 4'd3;
  localparam logic [3:0] S_CFIN   = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_WRAP   = 4'd7;
  localparam logic [3:0] S_WFIN   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0]    state, state_next;
  kpp_pkg::mop_t mop;
  logic          pose_valid, time_valid, is_pred;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd         = '0;
    cmd.mop     = mop;
    cmd.capture = in_valid && in_ready;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.opcode == 1'(kpp_pkg::OPCODE_INIT)) begin
          cmd.load_pose = 1'b1;
          state_next    = S_WRAP;
        end else if (!pose_valid) begin
          state_next = S_IDLE;
        end else begin
          cmd.rec_stamp = 1'b1;
          state_next    = (time_valid && status.dt_ok) ? S_CINIT : S_IDLE;
        end
      end
      S_CINIT: begin
        cmd.cordic_start = 1'b1;
        state_next       = S_CITER;
      end
      S_CITER: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_last) state_next = S_CFIN;
      end
      S_CFIN: begin
        cmd.cordic_fin = 1'b1;
        state_next     = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = (mop == kpp_pkg::OP_VAR2) ? S_WRAP : S_MUL;
      end
      S_WRAP: begin
        cmd.wrap_step = 1'b1;
        if (status.wrap_last) state_next = S_WFIN;
      end
      S_WFIN: begin
        cmd.wrap_fin = 1'b1;
        state_next   = is_pred ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mop        <= kpp_pkg::OP_VX;
      pose_valid <= 1'b0;
      time_valid <= 1'b0;
      is_pred    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECIDE) begin
        is_pred <= status.opcode;
        if (status.opcode == 1'(kpp_pkg::OPCODE_INIT)) begin
          pose_valid <= 1'b1;
          time_valid <= 1'b0;
        end else if (pose_valid) begin
          time_valid <= 1'b1;
        end
      end
      if (state == S_CFIN) begin
        mop <= kpp_pkg::OP_VX;
      end else if (state == S_ACC) begin
        mop <= mop + 4'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_capture_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_DECIDE)
    else $error("accepted item not decoded");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> pose_valid && time_valid && is_pred)
    else $error("result without predict");
  a_cordic_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CFIN |-> $past(state) == S_CITER)
    else $error("cordic finish out of order");
  a_init_flags: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pose |=> pose_valid && !time_valid)
    else $error("init flags wrong");
`endif

endmodule

@@ hw/rtl/kalman_predict_planar_pose.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_predict_planar_pose
// Kalman predict for a planar robot pose, 16 fraction bits, Q16.16 position.
// ----------------------------------------------------------------------------
// One item at a time. A predict item that yields a result runs CORDIC_STEPS
// iterations (18 by default) of the one-iteration-per-cycle CORDIC, then the
// single shared multiplier, which takes a multiply and an accumulate state
// per product for nine products, then a six-step heading wrap; it takes
// longer while the previous result still waits in the output register. An
// init item loads the pose and runs only the heading wrap; a skipped or
// stamp-only predict item ends in the decode state. The result sits in an
// output register so the next item is taken while a result waits. The x-y
// covariance is always zero under this predict step and reads as zero.
module kalman_predict_planar_pose (
  input  logic                          clk,
  input  logic                          rst,
  kpp_req_if.sink                       req,
  kpp_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [kpp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [kpp_pkg::NOISE_W-1:0]   cfg_data
);

  kpp_pkg::cmd_t    cmd;
  kpp_pkg::status_t status;
  logic             in_ready;

  assign req.ready  = in_ready;
  assign rsp.cov_xy = '0;

  kpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kpp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (req.opcode),
    .pose_x       (req.pose_x),
    .pose_y       (req.pose_y),
    .pose_heading (req.pose_heading),
    .speed        (req.speed),
    .turn_rate    (req.turn_rate),
    .stamp        (req.stamp),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .est_x        (rsp.est_x),
    .est_y        (rsp.est_y),
    .est_heading  (rsp.est_heading),
    .var_x        (rsp.var_x),
    .var_y        (rsp.var_y),
    .var_heading  (rsp.var_heading)
  );

endmodule
